### rtl/core/swdfs_pkg.sv
// Shared types, codes and constants of the sliding-window distinct-flow sketch.
`default_nettype none
package swdfs_pkg;

  localparam int WORD_W = 32;
  // Numerator width of the estimate division: 32-bit limit, count and 16 fraction bits
  localparam int NUM_DW = 56;
  localparam int DIV_CNT_W = 6;
  // Estimate sum cap is 2^48, so the sum register has 49 bits
  localparam int SUM_W = 49;

  localparam logic [WORD_W-1:0] FP_LIMIT = 32'hFFFF_FFFF;
  localparam logic [WORD_W-1:0] ZS_INIT = 32'hFFFF_FFFF;

  // Operation codes of the mode field
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_REMOVE = 2'd1;
  localparam logic [1:0] MODE_ESTIMATE = 2'd2;
  localparam logic [1:0] MODE_NONE = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_WINDOW = 2'd0;
  localparam logic [1:0] CFG_BKT_SEED = 2'd1;
  localparam logic [1:0] CFG_FP_SEED = 2'd2;

  // MurmurHash3 x86_32 constants
  localparam logic [WORD_W-1:0] MM_C1 = 32'hcc9e_2d51;
  localparam logic [WORD_W-1:0] MM_C2 = 32'h1b87_3593;
  localparam logic [WORD_W-1:0] MM_C3 = 32'h85eb_ca6b;
  localparam logic [WORD_W-1:0] MM_C4 = 32'hc2b2_ae35;
  localparam logic [WORD_W-1:0] MM_ADD = 32'he654_6b64;
  localparam logic [3:0] HASH_LAST = 4'd9;

  typedef struct packed {
    logic [1:0]        mode;
    logic [WORD_W-1:0] flow_key;
    logic [WORD_W-1:0] now;
  } in_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] distinct_estimate;
    logic              overflow;
  } out_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] fp;
    logic [WORD_W-1:0] stamp;
  } cell_t;

  typedef struct packed {
    logic [WORD_W-1:0] thr;
    logic [WORD_W-1:0] ru;
    logic [WORD_W-1:0] rus;
    logic              cred;
  } bucket_t;

  // Controller to datapath
  typedef struct packed {
    logic clr;
    logic take;
    logic hash;
    logic div_bkt;
    logic bkt_set;
    logic brd;
    logic bev;
    logic crd;
    logic cev;
    logic fin;
    logic bwr;
    logic div_est;
    logic acc;
    logic out_load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       clr_done;
    logic       hash_done;
    logic       div_done;
    logic       mod_done;
    logic       bkt_pow2;
    logic       last_cell;
    logic       last_bucket;
    logic       match;
    logic       need_div;
    logic       out_free;
    logic [1:0] mode;
  } stat_t;

endpackage
`default_nettype wire

### rtl/core/sliding_window_distinct_flow_sketch_top.sv
// Top level of the sliding-window distinct-flow sketch.
//
//   channel | signals                          | direction | transfer when
//   --------+----------------------------------+-----------+-------------------------
//   in      | in_valid, in_stall, in_data      | to block  | in_valid && !in_stall
//   out     | out_valid, out_stall, out_data   | from block| out_valid && !out_stall
//   cfg     | cfg_valid, cfg_ready, cfg_index, | to block  | cfg_valid && cfg_ready
//           | cfg_data                         |           |
//
// Insert/remove: take, hash steps, bucket modulo (plus reciprocal modulo steps when
// NUM_BUCKETS is not a power of two), bucket read and evaluation, a read and an
// evaluation per cell of the bucket, then the finish or write-back step of an insert.
// Estimate: per bucket a bucket read and evaluation, a read and an evaluation per cell,
// a sum step and a next step, plus a bit-serial division when it holds live cells.
// After reset a clearing pass over all NUM_BUCKETS*CELLS_PER_BUCKET cells runs with
// in_stall high; configuration writes are taken at all times.
// A finished estimate waits in the output register while new items are accepted.
`default_nettype none
module sliding_window_distinct_flow_sketch_top
  import swdfs_pkg::*;
#(
  parameter int NUM_BUCKETS = 64,
  parameter int CELLS_PER_BUCKET = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire in_item_t          in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data
);

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  swdfs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_mode  (in_data.mode),
    .in_stall (in_stall),
    .cmd      (cmd),
    .st       (st)
  );

  swdfs_dp #(
    .NUM_BUCKETS      (NUM_BUCKETS),
    .CELLS_PER_BUCKET (CELLS_PER_BUCKET)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // An accepted real operation keeps the block busy in the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && in_data.mode != MODE_NONE) |=> in_stall)
    else $error("block not busy after accepting an operation");

  // A new result only appears at the end of busy work
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised without work in progress");

  // Reset drops any pending result
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire

### rtl/core/swdfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module swdfs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/core/swdfs_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module swdfs_div
  import swdfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [NUM_DW-1:0] num,
  input  wire logic [WORD_W-1:0] den,
  output logic                   done,
  output logic [NUM_DW-1:0]      quo
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [WORD_W-1:0]    den_r;
  logic [WORD_W-1:0]    rem;
  logic [WORD_W:0]      trial;
  logic [WORD_W:0]      diff;
  logic                 ge;

  // Shift in the next dividend bit and try a subtract
  always_comb begin
    trial = {rem, quo[NUM_DW-1]};
    diff = trial - {1'b0, den_r};
    ge = (trial >= {1'b0, den_r});
  end

  // Iterate over all dividend bits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo <= num;
        rem <= '0;
        den_r <= den;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        quo <= {quo[NUM_DW-2:0], ge};
        rem <= ge ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(NUM_DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/core/swdfs_dp.sv
// Datapath: hashing, cell and bucket memories, scan registers, estimate sum.
`default_nettype none
module swdfs_dp
  import swdfs_pkg::*;
#(
  parameter int NUM_BUCKETS = 64,
  parameter int CELLS_PER_BUCKET = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cmd_t              cmd,
  output stat_t                  st,
  input  wire in_item_t          in_data,
  input  wire logic              cfg_valid,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output out_item_t              out_data
);

  localparam int TOTAL = NUM_BUCKETS * CELLS_PER_BUCKET;
  localparam int CAW = (TOTAL > 1) ? $clog2(TOTAL) : 1;
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int IW = (CELLS_PER_BUCKET > 1) ? $clog2(CELLS_PER_BUCKET) : 1;
  localparam int CW = $clog2(CELLS_PER_BUCKET + 1);
  localparam bit POW2 = ((NUM_BUCKETS & (NUM_BUCKETS - 1)) == 0);
  localparam logic [BW-1:0] BMASK = BW'(NUM_BUCKETS - 1);
  localparam logic [SUM_W-1:0] SUM_CAP = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [WORD_W-1:0] NB_W = WORD_W'(NUM_BUCKETS);
  // Reciprocal of the bucket count; the quotient estimate is at most two low
  localparam logic [WORD_W-1:0] RECIP = WORD_W'(64'hFFFF_FFFF / 64'(NUM_BUCKETS));

  // Configuration
  logic [WORD_W-1:0] wl;
  logic [WORD_W-1:0] seed_b;
  logic [WORD_W-1:0] seed_f;

  // Item and hash registers
  logic [1:0]        mode;
  logic [WORD_W-1:0] key;
  logic [WORD_W-1:0] now;
  logic [3:0]        hstep;
  logic [WORD_W-1:0] kreg;
  logic [WORD_W-1:0] hacc;
  logic [WORD_W-1:0] hb;
  logic [WORD_W-1:0] fp;
  logic [BW-1:0]     bucket;

  // Bucket and scan registers
  logic [WORD_W-1:0] thr;
  logic [WORD_W-1:0] ru;
  logic [WORD_W-1:0] rus;
  logic              cred;
  logic [IW-1:0]     idx;
  logic              have_free;
  logic [IW-1:0]     free_idx;
  logic [WORD_W-1:0] max_val;
  logic [IW-1:0]     max_idx;
  logic [CW-1:0]     cnt;

  // Estimate registers
  logic [BW-1:0]     eb;
  logic [SUM_W-1:0]  sum;
  logic              flag;
  logic [CAW-1:0]    clr_cnt;

  // Bucket modulo registers
  logic [1:0]          mstep;
  logic [WORD_W-1:0]   mq;
  logic [WORD_W-1:0]   mr;
  logic [2*WORD_W-1:0] m_prod;
  logic [WORD_W-1:0]   m_r1;
  logic [WORD_W-1:0]   m_r2;

  // Hash step logic
  logic [WORD_W-1:0] h_seed;
  logic [WORD_W-1:0] h_v;
  logic [WORD_W-1:0] h_x;
  logic [WORD_W-1:0] h_a;
  logic [WORD_W-1:0] h_mix;
  logic [WORD_W-1:0] h_fin;
  logic [WORD_W-1:0] h_k15;

  always_comb begin
    h_seed = (hstep < 4'd6) ? seed_b : seed_f;
    h_v = h_seed ^ kreg;
    h_x = {h_v[18:0], h_v[31:19]};
    h_a = ((h_x << 2) + h_x + MM_ADD) ^ 32'd4;
    h_mix = h_a ^ (h_a >> 16);
    h_fin = hacc ^ (hacc >> 16);
    h_k15 = {hacc[16:0], hacc[31:17]};
  end

  // Bucket modulo by reciprocal multiplication and two correction steps
  always_comb begin
    m_prod = (2*WORD_W)'(hb) * (2*WORD_W)'(RECIP);
    m_r1 = (mr >= NB_W) ? mr - NB_W : mr;
    m_r2 = (m_r1 >= NB_W) ? m_r1 - NB_W : m_r1;
  end

  // Divider
  logic              div_start;
  logic [NUM_DW-1:0] div_num;
  logic [WORD_W-1:0] div_den;
  logic              div_done;
  logic [NUM_DW-1:0] div_quo;
  logic [WORD_W+CW-1:0] est_prod;

  always_comb begin
    est_prod = FP_LIMIT * (WORD_W+CW)'(cnt);
    div_start = cmd.div_est;
    div_num = NUM_DW'({est_prod, 16'h0000});
    div_den = thr;
  end

  swdfs_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // Memories
  logic [BW-1:0]  bsel;
  logic [CAW-1:0] cbase;
  logic [CAW-1:0] craddr;
  logic           cwe;
  logic [CAW-1:0] cwaddr;
  cell_t          cwdata;
  cell_t          crd;
  logic [$bits(cell_t)-1:0] crd_raw;
  logic           bwe;
  logic [BW-1:0]  bwaddr;
  bucket_t        bwdata;
  bucket_t        brd;
  logic [$bits(bucket_t)-1:0] brd_raw;

  assign crd = cell_t'(crd_raw);
  assign brd = bucket_t'(brd_raw);

  always_comb begin
    bsel = (mode == MODE_ESTIMATE) ? eb : bucket;
    cbase = CAW'((CAW+1)'(bsel) * (CAW+1)'(CELLS_PER_BUCKET));
    craddr = cbase + CAW'(idx);
  end

  // Cell scan evaluation
  logic              c_free;
  logic              c_match;
  logic              c_live;

  always_comb begin
    c_free = (crd.fp == FP_LIMIT) || (now >= crd.stamp + wl);
    c_match = (crd.fp == fp);
    c_live = (crd.fp != FP_LIMIT) && (now < wl + crd.stamp) && (crd.fp < thr);
  end

  // Insert finish: place the fingerprint, update threshold and runner-up
  bucket_t           fin_bkt;
  logic              fin_cwe;
  logic [IW-1:0]     fin_idx;
  logic [WORD_W-1:0] fv;

  always_comb begin
    fin_bkt = '{thr: thr, ru: ru, rus: rus, cred: cred};
    fin_cwe = 1'b0;
    fin_idx = free_idx;
    fv = fp;
    if (have_free) begin
      fin_cwe = 1'b1;
      if (ru < fp && thr < fp && cred) begin
        fin_bkt.ru = fp;
        fin_bkt.rus = now;
        fin_bkt.cred = 1'b0;
      end
    end else begin
      if (max_val > fp) begin
        fin_cwe = 1'b1;
        fin_idx = max_idx;
        fv = max_val;
      end
      if (fv < thr) begin
        fin_bkt.ru = thr;
        fin_bkt.thr = fv;
      end
      if (fv < fin_bkt.ru) begin
        fin_bkt.ru = fv;
      end
    end
  end

  // Write port selection
  always_comb begin
    cwe = 1'b0;
    cwaddr = craddr;
    cwdata = '{fp: FP_LIMIT, stamp: now};
    if (cmd.clr) begin
      cwe = 1'b1;
      cwaddr = clr_cnt;
      cwdata = '{fp: FP_LIMIT, stamp: '0};
    end else if (cmd.cev) begin
      cwe = c_match && (mode == MODE_INSERT || mode == MODE_REMOVE);
      cwdata = '{fp: (mode == MODE_INSERT) ? crd.fp : FP_LIMIT, stamp: now};
    end else if (cmd.fin) begin
      cwe = fin_cwe;
      cwaddr = cbase + CAW'(fin_idx);
      cwdata = '{fp: fp, stamp: now};
    end
    bwe = 1'b0;
    bwaddr = bucket;
    bwdata = fin_bkt;
    if (cmd.clr) begin
      bwe = ((CAW+1)'(clr_cnt) < (CAW+1)'(NUM_BUCKETS));
      bwaddr = BW'(clr_cnt);
      bwdata = '{thr: FP_LIMIT, ru: '0, rus: ZS_INIT, cred: 1'b1};
    end else if (cmd.fin) begin
      bwe = 1'b1;
    end else if (cmd.bwr) begin
      bwe = 1'b1;
      bwdata = '{thr: thr, ru: ru, rus: rus, cred: cred};
    end
  end

  swdfs_ram #(.WIDTH($bits(cell_t)), .DEPTH(TOTAL)) u_cell_ram (
    .clk   (clk),
    .we    (cwe),
    .waddr (cwaddr),
    .wdata (cwdata),
    .re    (cmd.crd),
    .raddr (craddr),
    .rdata (crd_raw)
  );

  swdfs_ram #(.WIDTH($bits(bucket_t)), .DEPTH(NUM_BUCKETS)) u_bkt_ram (
    .clk   (clk),
    .we    (bwe),
    .waddr (bwaddr),
    .wdata (bwdata),
    .re    (cmd.brd),
    .raddr (bsel),
    .rdata (brd_raw)
  );

  // Estimate accumulation with saturation
  logic [NUM_DW:0] acc_sum;
  assign acc_sum = (NUM_DW+1)'(sum) + (NUM_DW+1)'(div_quo);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wl <= '0;
      seed_b <= '0;
      seed_f <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW:   wl <= cfg_data;
        CFG_BKT_SEED: seed_b <= cfg_data;
        CFG_FP_SEED:  seed_f <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clearing pass counter
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  // Advance the bucket modulo steps
  always_ff @(posedge clk) begin
    if (rst) begin
      mstep <= 2'd0;
    end else if (cmd.div_bkt) begin
      mstep <= 2'd1;
    end else if (mstep == 2'd1) begin
      mstep <= 2'd2;
    end else if (cmd.bkt_set) begin
      mstep <= 2'd0;
    end
  end

  // Item, hash and scan registers
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mode <= in_data.mode;
      key <= in_data.flow_key;
      now <= in_data.now;
      hstep <= '0;
      eb <= '0;
      sum <= '0;
      flag <= 1'b0;
    end
    if (cmd.hash) begin
      hstep <= hstep + 1'b1;
      unique case (hstep)
        4'd0:       hacc <= key * MM_C1;
        4'd1:       kreg <= h_k15 * MM_C2;
        4'd2, 4'd6: hacc <= h_mix;
        4'd3, 4'd7: hacc <= hacc * MM_C3;
        4'd4, 4'd8: hacc <= (hacc ^ (hacc >> 13)) * MM_C4;
        4'd5:       hb <= h_fin;
        4'd9:       fp <= (h_fin == FP_LIMIT) ? '0 : h_fin;
        default: ;
      endcase
    end
    if (cmd.div_bkt) begin
      mq <= m_prod[2*WORD_W-1:WORD_W];
    end
    if (mstep == 2'd1) begin
      mr <= hb - mq * NB_W;
    end
    if (cmd.bkt_set) begin
      bucket <= POW2 ? (hb[BW-1:0] & BMASK) : m_r2[BW-1:0];
    end
    // Latch bucket state, expire the runner-up on insert
    if (cmd.bev) begin
      thr <= brd.thr;
      ru <= brd.ru;
      rus <= brd.rus;
      cred <= brd.cred;
      if (mode == MODE_INSERT && now >= wl + brd.rus) begin
        thr <= brd.ru;
        rus <= ZS_INIT;
        cred <= 1'b1;
      end
      idx <= '0;
      have_free <= 1'b0;
      cnt <= '0;
    end
    if (cmd.cev) begin
      idx <= idx + 1'b1;
      if (c_free) begin
        have_free <= 1'b1;
        free_idx <= idx;
      end
      if (idx == '0 || crd.fp > max_val) begin
        max_val <= crd.fp;
        max_idx <= idx;
      end
      if (c_live) begin
        cnt <= cnt + 1'b1;
      end
    end
    if (cmd.acc) begin
      eb <= eb + 1'b1;
      if (thr == '0) begin
        flag <= 1'b1;
      end else if (cnt != '0) begin
        sum <= (acc_sum >= (NUM_DW+1)'(SUM_CAP)) ? SUM_CAP : SUM_W'(acc_sum);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
      out_data.distinct_estimate <= sum[SUM_W-1] ? FP_LIMIT : sum[SUM_W-2:16];
      out_data.overflow <= flag | sum[SUM_W-1];
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Status
  always_comb begin
    st.clr_done = (clr_cnt == CAW'(TOTAL - 1));
    st.hash_done = (hstep == HASH_LAST);
    st.div_done = div_done;
    st.mod_done = (mstep == 2'd2);
    st.bkt_pow2 = POW2;
    st.last_cell = (idx == IW'(CELLS_PER_BUCKET - 1));
    st.last_bucket = (eb == BW'(NUM_BUCKETS - 1));
    st.match = c_match;
    st.need_div = (thr != '0) && (cnt != '0);
    st.out_free = !out_valid || !out_stall;
    st.mode = mode;
  end

endmodule
`default_nettype wire

### rtl/core/swdfs_ctrl.sv
// Controller state machine sequencing hash, scan, finish and estimate steps.
`default_nettype none
module swdfs_ctrl
  import swdfs_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic [1:0] in_mode,
  output logic            in_stall,
  output cmd_t            cmd,
  input  wire stat_t      st
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_HASH, S_BMOD, S_BDIV, S_BRD, S_BEV, S_CRD, S_CEV,
    S_FIN, S_BWR, S_ESUM, S_EDIV, S_ENEXT, S_OUT
  } state_t;

  state_t state;
  state_t state_next;

  // Next state and commands
  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_done) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (in_mode == MODE_ESTIMATE) state_next = S_BRD;
          else if (in_mode == MODE_NONE) state_next = S_IDLE;
          else state_next = S_HASH;
        end
      end
      S_HASH: begin
        cmd.hash = 1'b1;
        if (st.hash_done) state_next = S_BMOD;
      end
      S_BMOD: begin
        if (st.bkt_pow2) begin
          cmd.bkt_set = 1'b1;
          state_next = S_BRD;
        end else begin
          cmd.div_bkt = 1'b1;
          state_next = S_BDIV;
        end
      end
      S_BDIV: begin
        if (st.mod_done) begin
          cmd.bkt_set = 1'b1;
          state_next = S_BRD;
        end
      end
      S_BRD: begin
        cmd.brd = 1'b1;
        state_next = S_BEV;
      end
      S_BEV: begin
        cmd.bev = 1'b1;
        state_next = S_CRD;
      end
      S_CRD: begin
        cmd.crd = 1'b1;
        state_next = S_CEV;
      end
      S_CEV: begin
        cmd.cev = 1'b1;
        if (st.mode == MODE_INSERT && st.match) state_next = S_BWR;
        else if (!st.last_cell) state_next = S_CRD;
        else if (st.mode == MODE_INSERT) state_next = S_FIN;
        else if (st.mode == MODE_ESTIMATE) state_next = S_ESUM;
        else state_next = S_IDLE;
      end
      S_FIN: begin
        cmd.fin = 1'b1;
        state_next = S_IDLE;
      end
      S_BWR: begin
        cmd.bwr = 1'b1;
        state_next = S_IDLE;
      end
      S_ESUM: begin
        if (st.need_div) begin
          cmd.div_est = 1'b1;
          state_next = S_EDIV;
        end else begin
          state_next = S_ENEXT;
        end
      end
      S_EDIV: begin
        if (st.div_done) state_next = S_ENEXT;
      end
      S_ENEXT: begin
        cmd.acc = 1'b1;
        state_next = st.last_bucket ? S_OUT : S_BRD;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

endmodule
`default_nettype wire

### dv/swdfs_checker.sv
// Checker of the distinct-flow sketch: predicts every estimate and compares each output transfer.
module swdfs_checker
  import swdfs_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_stall,
  input  wire in_item_t          in_data,
  input  wire logic              out_valid,
  input  wire logic              out_stall,
  input  wire out_item_t         out_data,
  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [WORD_W-1:0] cfg_data,
  output int                     errors,
  output int                     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NB = 64;
  localparam int NC = 8;
  localparam logic [63:0] SUM_CAP = 64'd1 << 48;

  logic [31:0] window_len, bkt_seed, fp_seed;
  logic [31:0] cell_fp [NB*NC];
  logic [31:0] cell_ts [NB*NC];
  logic [31:0] thr [NB];
  logic [31:0] ru [NB];
  logic [31:0] ru_ts [NB];
  bit          ru_credit [NB];
  out_item_t   estimates_due [$];

  function automatic logic [31:0] rotl(logic [31:0] x, int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // Single-block MurmurHash3 x86_32 of a four-byte key
  function automatic logic [31:0] murmur_word(logic [31:0] key, logic [31:0] seed);
    logic [31:0] k, h;
    k = key * MM_C1;
    k = rotl(k, 15);
    k = k * MM_C2;
    h = seed ^ k;
    h = rotl(h, 13);
    h = h * 32'd5 + MM_ADD;
    h = h ^ 32'd4;
    h = h ^ (h >> 16);
    h = h * MM_C3;
    h = h ^ (h >> 13);
    h = h * MM_C4;
    h = h ^ (h >> 16);
    return h;
  endfunction

  task automatic clear_sketch();
    for (int i = 0; i < NB*NC; i++) begin
      cell_fp[i] = FP_LIMIT;
      cell_ts[i] = '0;
    end
    for (int b = 0; b < NB; b++) begin
      thr[b] = FP_LIMIT;
      ru[b] = '0;
      ru_ts[b] = ZS_INIT;
      ru_credit[b] = 1'b1;
    end
  endtask

  task automatic insert_flow(int b, logic [31:0] fp, logic [31:0] now);
    int base, free_idx, max_idx;
    bit have_free;
    logic [31:0] v, max_val, lim;
    base = b * NC;
    have_free = 0;
    free_idx = 0;
    // Expire the runner-up into the threshold
    lim = window_len + ru_ts[b];
    if (now >= lim) begin
      thr[b] = ru[b];
      ru_ts[b] = ZS_INIT;
      ru_credit[b] = 1'b1;
    end
    for (int i = 0; i < NC; i++) begin
      v = cell_fp[base+i];
      lim = cell_ts[base+i] + window_len;
      if (v == FP_LIMIT || now >= lim) begin
        have_free = 1;
        free_idx = i;
      end
      if (v == fp) begin
        cell_ts[base+i] = now;
        return;
      end
    end
    if (have_free) begin
      cell_fp[base+free_idx] = fp;
      cell_ts[base+free_idx] = now;
      if (ru[b] < fp && thr[b] < fp && ru_credit[b]) begin
        ru[b] = fp;
        ru_ts[b] = now;
        ru_credit[b] = 1'b0;
      end
      return;
    end
    // Bucket full: swap out the largest fingerprint
    max_idx = 0;
    max_val = cell_fp[base];
    for (int i = 1; i < NC; i++) begin
      if (cell_fp[base+i] > max_val) begin
        max_val = cell_fp[base+i];
        max_idx = i;
      end
    end
    if (max_val > fp) begin
      cell_fp[base+max_idx] = fp;
      cell_ts[base+max_idx] = now;
      fp = max_val;
    end
    if (fp < thr[b]) begin
      ru[b] = thr[b];
      thr[b] = fp;
    end
    if (fp < ru[b]) ru[b] = fp;
  endtask

  function automatic out_item_t estimate_count(logic [31:0] now);
    out_item_t r;
    logic [63:0] sum, cnt;
    logic [31:0] g, v, lim;
    sum = '0;
    r.overflow = 1'b0;
    for (int b = 0; b < NB; b++) begin
      g = thr[b];
      if (g == 0) begin
        r.overflow = 1'b1;
        continue;
      end
      cnt = '0;
      for (int i = 0; i < NC; i++) begin
        v = cell_fp[b*NC+i];
        lim = window_len + cell_ts[b*NC+i];
        if (v != FP_LIMIT && now < lim && v < g) cnt++;
      end
      sum += ((64'(FP_LIMIT) * cnt) << 16) / 64'(g);
      if (sum >= SUM_CAP) sum = SUM_CAP;
    end
    if (sum >= SUM_CAP) begin
      r.distinct_estimate = '1;
      r.overflow = 1'b1;
    end else begin
      r.distinct_estimate = sum[47:16];
    end
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    logic [31:0] b_idx, fp;
    out_item_t want;
    if (rst) begin
      window_len = '0;
      bkt_seed = '0;
      fp_seed = '0;
      clear_sketch();
      estimates_due.delete();
    end else begin
      // Track configuration writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WINDOW:   window_len = cfg_data;
          CFG_BKT_SEED: bkt_seed = cfg_data;
          CFG_FP_SEED:  fp_seed = cfg_data;
          default: ;
        endcase
      end
      // Advance the sketch on each input transfer
      if (in_valid && !in_stall) begin
        b_idx = murmur_word(in_data.flow_key, bkt_seed) % NB;
        fp = murmur_word(in_data.flow_key, fp_seed) % FP_LIMIT;
        case (in_data.mode)
          MODE_INSERT: insert_flow(int'(b_idx), fp, in_data.now);
          MODE_REMOVE: begin
            for (int i = 0; i < NC; i++) begin
              if (cell_fp[b_idx*NC+i] == fp) begin
                cell_fp[b_idx*NC+i] = FP_LIMIT;
                cell_ts[b_idx*NC+i] = in_data.now;
              end
            end
          end
          MODE_ESTIMATE: estimates_due.push_back(estimate_count(in_data.now));
          default: ;
        endcase
      end
      // Compare each output transfer with the oldest estimate
      if (out_valid && !out_stall) begin
        if (estimates_due.size() == 0) begin
          report("unexpected output", out_data.distinct_estimate, 32'h0);
        end else begin
          want = estimates_due.pop_front();
          if (out_data.distinct_estimate !== want.distinct_estimate)
            report("distinct_estimate", out_data.distinct_estimate, want.distinct_estimate);
          if (out_data.overflow !== want.overflow)
            report("overflow", 32'(out_data.overflow), 32'(want.overflow));
        end
      end
    end
    pending <= estimates_due.size();
  end
endmodule

### dv/testbench.sv
// Top of the distinct-flow sketch testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
  import swdfs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int STALL_PCT = 21;
  localparam int IDLE_LIMIT = 30000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 12000;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  in_item_t in_data;
  out_item_t out_data;
  logic [1:0] cfg_index;
  logic [31:0] cfg_data;
  int errors, pending;

  bit quiet, hold_req;
  int idle_cycles;
  logic [31:0] clock_now;
  logic [31:0] key_pool [64];

  sliding_window_distinct_flow_sketch_top u_top (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  swdfs_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .in_data, .out_valid, .out_stall, .out_data,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, or one long hold when requested
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (quiet) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < STALL_PCT);
      end
    end
  end

  // Watchdog: end the run after too long without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send(logic [1:0] mode, logic [31:0] key, logic [31:0] now);
    in_item_t it;
    it.mode = mode;
    it.flow_key = key;
    it.now = now;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < STALL_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] value);
    @(negedge clk);
    in_valid <= 1'b0;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until every estimate has come and inserts have settled
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic send_random();
    int pick;
    logic [1:0] mode;
    logic [31:0] key, now;
    pick = $urandom_range(99);
    mode = (pick < 68) ? MODE_INSERT : (pick < 86) ? MODE_REMOVE :
           (pick < 94) ? MODE_ESTIMATE : MODE_NONE;
    key = ($urandom_range(1)) ? key_pool[$urandom_range(63)] : $urandom;
    clock_now += $urandom_range(0, 30);
    now = ($urandom_range(99) < 5) ? $urandom : clock_now;
    send(mode, key, now);
  endtask

  initial begin
    logic [31:0] windows [5];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_WINDOW;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    clock_now = '0;
    for (int i = 0; i < 64; i++) key_pool[i] = $urandom;
    windows = '{32'd0, 32'hFFFF_FFFF, 32'd200, 32'd60, $urandom_range(1, 2000)};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: field extremes, every mode, zero threshold after expiry
    send(MODE_ESTIMATE, 32'h0, 32'h0);
    send(MODE_INSERT, 32'h0, 32'h0);
    send(MODE_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(MODE_ESTIMATE, 32'h0, 32'hFFFF_FFFF);
    send(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0);
    send(MODE_ESTIMATE, 32'hFFFF_FFFF, 32'h0);
    drain();
    write_reg(CFG_WINDOW, 32'd100);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    for (int i = 0; i < 10; i++) send(MODE_INSERT, key_pool[i], 32'd10 * i);
    send(MODE_ESTIMATE, 32'h0, 32'd95);
    send(MODE_REMOVE, key_pool[3], 32'd96);
    send(MODE_INSERT, key_pool[0], 32'd500);
    send(MODE_ESTIMATE, 32'h0, 32'd500);
    send(MODE_ESTIMATE, 32'h0, 32'd5000);
    drain();

    // Random phases over several register settings
    for (int ph = 0; ph < 5; ph++) begin
      write_reg(CFG_WINDOW, windows[ph]);
      write_reg(CFG_BKT_SEED, (ph == 1) ? 32'hFFFF_FFFF : (ph == 0) ? 32'h0 : $urandom);
      write_reg(CFG_FP_SEED, (ph == 1) ? 32'hFFFF_FFFF : (ph == 0) ? 32'h0 : $urandom);
      clock_now = (ph == 3) ? 32'hFFFF_FF00 : $urandom_range(0, 1000);
      quiet = (ph == 2);
      for (int n = 0; n < 220; n++) begin
        if (ph == 3 && n == 100) begin
          // Hold the receiver while estimates pile up
          hold_req = 1'b1;
          repeat (3) send(MODE_ESTIMATE, $urandom, clock_now);
        end
        if (ph == 4 && n == 110) begin
          @(negedge clk);
          in_valid <= 1'b0;
          wait (pending == 0);
        end
        send_random();
      end
      drain();
    end

    quiet = 1'b0;
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

### sliding_window_distinct_flow_sketch_top.f
rtl/core/swdfs_pkg.sv
rtl/core/swdfs_ram.sv
rtl/core/swdfs_div.sv
rtl/core/swdfs_dp.sv
rtl/core/swdfs_ctrl.sv
rtl/core/sliding_window_distinct_flow_sketch_top.sv
dv/swdfs_checker.sv
dv/testbench.sv
